>>> sv/frame_bitmap_allocator_unit_assert.svh
// Assertion macros for the frame bitmap allocator.
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define FBA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fba assertion failed");

`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fba assertion failed");

`else

`define FBA_ASSERT_IMP(label, clk, rst, ante, cons)

`define FBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/fba_pkg.sv
package fba_pkg;

   localparam int MAP_BYTES   = 512;
   localparam int FRAME_W     = 12;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int FIELD_LIMIT = 1 << FRAME_W;
   localparam int FRAME_LIMIT = (MAP_BYTES * 8 < FIELD_LIMIT) ? MAP_BYTES * 8 : FIELD_LIMIT;
   localparam int SCAN_BYTES  = (FRAME_LIMIT + 7) / 8;
   localparam int SCAN_ADDR_W = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;

   localparam logic [7:0] FULL_BYTE = 8'hFF;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC     = 2'd0,
      CMD_MARK_USED = 2'd1,
      CMD_MARK_FREE = 2'd2,
      CMD_NONE      = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic       full;
      logic [2:0] free_bit;
      logic [7:0] new_byte;
   } byte_result_type;

endpackage

>>> sv/fba_map_ram.sv
module fba_map_ram #(
   parameter int DEPTH  = 512,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/fba_byte_unit.sv
module fba_byte_unit (
   input  logic [7:0]               map_byte,
   input  fba_pkg::cmd_type         cmd,
   input  logic [2:0]               bit_sel,
   output fba_pkg::byte_result_type result
);
   import fba_pkg::*;

   logic [2:0] free_bit;
   logic [7:0] mask;

   // lowest clear bit wins
   always_comb begin
      free_bit = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (!map_byte[k]) begin
            free_bit = 3'(k);
         end
      end
   end

   always_comb begin
      mask = 8'd0;
      result.full     = (map_byte == FULL_BYTE);
      result.free_bit = free_bit;
      result.new_byte = map_byte;
      case (cmd)
         CMD_ALLOC: begin
            mask = 8'd1 << free_bit;
            result.new_byte = map_byte | mask;
         end
         CMD_MARK_USED: begin
            mask = 8'd1 << bit_sel;
            result.new_byte = map_byte | mask;
         end
         CMD_MARK_FREE: begin
            mask = 8'd1 << bit_sel;
            result.new_byte = map_byte & ~mask;
         end
         default: begin
            result.new_byte = map_byte;
         end
      endcase
   end

endmodule

>>> sv/frame_bitmap_allocator_unit.sv
// Commands: mark used and mark free read the map byte, then write it back in ST_MARK and
// show the result; the unused command and an out-of-range mark are answered from idle.
// Allocate reads bytes from the hint on, one per cycle, to a free frame or the map's end.
// Throughput: busy drops in the cycle the result is shown, so the next request can be
// taken then; results cannot be stalled by the receiver.
// Reset: clears the map with one byte written per cycle, all SCAN_BYTES (512), busy meanwhile.
`include "frame_bitmap_allocator_unit_assert.svh"

module frame_bitmap_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fba_pkg::CMD_W-1:0]     req_cmd,
   input  logic [fba_pkg::FRAME_W-1:0]   req_frame_number,
   output logic                          rsp_valid,
   output logic [fba_pkg::FRAME_W-1:0]   rsp_frame_out,
   output logic [fba_pkg::STATUS_W-1:0]  rsp_status
);
   import fba_pkg::*;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [FRAME_W-1:0]       fnum_ff, fnum_in;
   logic [SCAN_ADDR_W-1:0]   addr_ff, addr_in;
   logic [SCAN_ADDR_W-1:0]   hint_ff, hint_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]       rsp_frame_ff, rsp_frame_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     wr_en;
   logic [SCAN_ADDR_W-1:0]   wr_addr;
   logic [7:0]               wr_data;
   logic [SCAN_ADDR_W-1:0]   rd_addr;
   logic [7:0]               rd_data;
   byte_result_type          unit_res;
   logic                     accept;
   logic                     in_range;

   fba_map_ram #(
      .DEPTH  (SCAN_BYTES),
      .WIDTH  (8),
      .ADDR_W (SCAN_ADDR_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fba_byte_unit u_byte (
      .map_byte (rd_data),
      .cmd      (cmd_ff),
      .bit_sel  (fnum_ff[2:0]),
      .result   (unit_res)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_frame_number} < (FRAME_W+1)'(FRAME_LIMIT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      fnum_ff       <= fnum_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      fnum_in       = fnum_ff;
      addr_in       = addr_ff;
      hint_in       = hint_ff;
      rsp_valid_in  = 1'b0;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = unit_res.new_byte;
      rd_addr       = addr_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = 8'd0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == SCAN_ADDR_W'(SCAN_BYTES - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = cmd_type'(req_cmd);
               fnum_in = req_frame_number;
               unique case (cmd_type'(req_cmd))
                  CMD_ALLOC: begin
                     rd_addr  = hint_ff;
                     addr_in  = hint_ff;
                     state_in = ST_SCAN;
                  end
                  CMD_MARK_USED, CMD_MARK_FREE: begin
                     if (in_range) begin
                        rd_addr  = SCAN_ADDR_W'(req_frame_number >> 3);
                        addr_in  = SCAN_ADDR_W'(req_frame_number >> 3);
                        state_in = ST_MARK;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_frame_in  = req_frame_number;
                        rsp_status_in = STATUS_RANGE;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_frame_in  = req_frame_number;
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rd_data holds the byte at addr_ff; fetch the following one meanwhile
            rd_addr = addr_ff + 1'b1;
            if (!unit_res.full) begin
               wr_en         = 1'b1;
               hint_in       = addr_ff;
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = FRAME_W'({addr_ff, unit_res.free_bit});
               rsp_status_in = STATUS_OK;
               state_in      = ST_IDLE;
            end else if (addr_ff == SCAN_ADDR_W'(SCAN_BYTES - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_frame_in  = '0;
               rsp_status_in = STATUS_FULL;
               state_in      = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_MARK: begin
            wr_en = 1'b1;
            // freeing below the hint moves the first-fit start back
            if (cmd_ff == CMD_MARK_FREE && addr_ff < hint_ff) begin
               hint_in = addr_ff;
            end
            rsp_valid_in  = 1'b1;
            rsp_frame_in  = fnum_ff;
            rsp_status_in = STATUS_OK;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_frame_out = rsp_frame_ff;
   assign rsp_status    = rsp_status_ff;

   `FBA_ASSERT_IMP(a_no_rsp_in_clear, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)
   `FBA_ASSERT_IMP(a_full_frame_zero, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_FULL, rsp_frame_ff == '0)
   `FBA_ASSERT_IMP(a_write_states, clock, reset, wr_en, state_ff != ST_IDLE)
   `FBA_ASSERT_NEXT(a_work_then_rsp, clock, reset, state_ff == ST_MARK, rsp_valid_ff && state_ff == ST_IDLE)

endmodule
